// File: sv/rv64i_instruction_decoder_top_assert.svh
// Assertion macros used by the instruction decoder top level.
`ifndef RV64I_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RV64I_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVID_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RVID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rvid_pkg.sv
// Types, encodings and lookup tables for the RV64I instruction decoder.
`timescale 1ns / 1ps
package rvid_pkg;

  // Encoding format classes
  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_R    = 3'd1,
    FMT_I    = 3'd2,
    FMT_S    = 3'd3,
    FMT_B    = 3'd4,
    FMT_U    = 3'd5,
    FMT_J    = 3'd6
  } fmt_e;

  // Major opcodes
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP32     = 7'h3B;

  // funct3 codes that the decoder tests by value
  localparam logic [2:0] F3_ZERO = 3'd0;
  localparam logic [2:0] F3_SL   = 3'd1;
  localparam logic [2:0] F3_SD   = 3'd3;
  localparam logic [2:0] F3_SR   = 3'd5;

  // funct7 / funct6 patterns
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [5:0] F6_BASE = 6'b000000;
  localparam logic [5:0] F6_ALT  = 6'b010000;

  // Exact whole-word encodings
  localparam logic [31:0] WORD_FENCE_TSO = 32'b10000011001100000000000000001111;
  localparam logic [31:0] WORD_PAUSE     = 32'b00000001000000000000000000001111;
  localparam logic [31:0] WORD_ECALL     = 32'b00000000000000000000000001110011;
  localparam logic [31:0] WORD_EBREAK    = 32'b00000000000100000000000001110011;

  // Dense operation numbers in listing order
  localparam logic [5:0] OP_LUI    = 6'd0;
  localparam logic [5:0] OP_AUIPC  = 6'd1;
  localparam logic [5:0] OP_JAL    = 6'd2;
  localparam logic [5:0] OP_JALR   = 6'd3;
  localparam logic [5:0] OP_BEQ    = 6'd4;
  localparam logic [5:0] OP_BNE    = 6'd5;
  localparam logic [5:0] OP_BLT    = 6'd6;
  localparam logic [5:0] OP_BGE    = 6'd7;
  localparam logic [5:0] OP_BLTU   = 6'd8;
  localparam logic [5:0] OP_BGEU   = 6'd9;
  localparam logic [5:0] OP_LB     = 6'd10;
  localparam logic [5:0] OP_LH     = 6'd11;
  localparam logic [5:0] OP_LW     = 6'd12;
  localparam logic [5:0] OP_LBU    = 6'd13;
  localparam logic [5:0] OP_LHU    = 6'd14;
  localparam logic [5:0] OP_SB     = 6'd15;
  localparam logic [5:0] OP_SH     = 6'd16;
  localparam logic [5:0] OP_SW     = 6'd17;
  localparam logic [5:0] OP_ADDI   = 6'd18;
  localparam logic [5:0] OP_SLTI   = 6'd19;
  localparam logic [5:0] OP_SLTIU  = 6'd20;
  localparam logic [5:0] OP_XORI   = 6'd21;
  localparam logic [5:0] OP_ORI    = 6'd22;
  localparam logic [5:0] OP_ANDI   = 6'd23;
  localparam logic [5:0] OP_SLLI   = 6'd24;
  localparam logic [5:0] OP_SRLI   = 6'd25;
  localparam logic [5:0] OP_SRAI   = 6'd26;
  localparam logic [5:0] OP_ADD    = 6'd27;
  localparam logic [5:0] OP_SUB    = 6'd28;
  localparam logic [5:0] OP_SLL    = 6'd29;
  localparam logic [5:0] OP_SLT    = 6'd30;
  localparam logic [5:0] OP_SLTU   = 6'd31;
  localparam logic [5:0] OP_XOR    = 6'd32;
  localparam logic [5:0] OP_SRL    = 6'd33;
  localparam logic [5:0] OP_SRA    = 6'd34;
  localparam logic [5:0] OP_OR     = 6'd35;
  localparam logic [5:0] OP_AND    = 6'd36;
  localparam logic [5:0] OP_FENCE  = 6'd37;
  localparam logic [5:0] OP_FTSO   = 6'd38;
  localparam logic [5:0] OP_PAUSE  = 6'd39;
  localparam logic [5:0] OP_ECALL  = 6'd40;
  localparam logic [5:0] OP_EBREAK = 6'd41;
  localparam logic [5:0] OP_LWU    = 6'd42;
  localparam logic [5:0] OP_LD     = 6'd43;
  localparam logic [5:0] OP_SD     = 6'd44;
  localparam logic [5:0] OP_ADDIW  = 6'd45;
  localparam logic [5:0] OP_SLLIW  = 6'd46;
  localparam logic [5:0] OP_SRLIW  = 6'd47;
  localparam logic [5:0] OP_SRAIW  = 6'd48;
  localparam logic [5:0] OP_ADDW   = 6'd49;
  localparam logic [5:0] OP_SUBW   = 6'd50;
  localparam logic [5:0] OP_SLLW   = 6'd51;
  localparam logic [5:0] OP_SRLW   = 6'd52;
  localparam logic [5:0] OP_SRAW   = 6'd53;

  // funct3-indexed operation tables (entry 0 first)
  typedef logic [5:0] op_tab8_t [8];
  typedef logic [5:0] op_tab4_t [4];

  localparam op_tab8_t BRANCH_OPS = '{OP_BEQ, OP_BNE, '0, '0, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
  localparam logic [7:0] BRANCH_OK = 8'b1111_0011;
  localparam op_tab8_t LOAD_OPS = '{OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU, '0};
  localparam logic [7:0] LOAD_OK = 8'b0111_1111;
  localparam op_tab4_t STORE_OPS = '{OP_SB, OP_SH, OP_SW, OP_SD};
  localparam op_tab8_t OPIMM_OPS =
    '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_ORI, OP_ANDI};
  localparam op_tab8_t OP_OPS = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND};

  // Decoded fields of one instruction
  typedef struct packed {
    fmt_e        fmt;
    logic [5:0]  op;
    logic        legal;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm;
  } dec_t;

endpackage

// File: sv/rvid_decode.sv
// Combinational RV64I decode of one registered instruction word.
`timescale 1ns / 1ps
module rvid_decode
  import rvid_pkg::*;
(
  input  logic [31:0] instr_i,
  output dec_t        dec_o
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  fmt_e       fmt;
  logic [5:0] op;
  logic       ok;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];

  // Classify the word by opcode, funct3 and funct7
  always_comb begin
    fmt = FMT_NONE;
    op  = '0;
    ok  = 1'b0;
    unique case (opc)
      OPC_LUI: begin
        fmt = FMT_U; op = OP_LUI; ok = 1'b1;
      end
      OPC_AUIPC: begin
        fmt = FMT_U; op = OP_AUIPC; ok = 1'b1;
      end
      OPC_JAL: begin
        fmt = FMT_J; op = OP_JAL; ok = 1'b1;
      end
      OPC_JALR: begin
        if (f3 == F3_ZERO) begin
          fmt = FMT_I; op = OP_JALR; ok = 1'b1;
        end
      end
      OPC_BRANCH: begin
        fmt = FMT_B; op = BRANCH_OPS[f3]; ok = BRANCH_OK[f3];
      end
      OPC_LOAD: begin
        fmt = FMT_I; op = LOAD_OPS[f3]; ok = LOAD_OK[f3];
      end
      OPC_STORE: begin
        fmt = FMT_S;
        if (!f3[2]) begin
          op = STORE_OPS[f3[1:0]]; ok = 1'b1;
        end
      end
      OPC_OP_IMM: begin
        fmt = FMT_I; op = OPIMM_OPS[f3];
        priority if (f3 == F3_SL) begin
          ok = (f7[6:1] == F6_BASE);
        end else if (f3 == F3_SR) begin
          if (f7[6:1] == F6_BASE) begin
            ok = 1'b1;
          end else if (f7[6:1] == F6_ALT) begin
            ok = 1'b1; op = OP_SRAI;
          end
        end else begin
          ok = 1'b1;
        end
      end
      OPC_OP: begin
        fmt = FMT_R; op = OP_OPS[f3];
        priority if (f7 == F7_BASE) begin
          ok = 1'b1;
        end else if (f7 == F7_ALT && f3 == F3_ZERO) begin
          ok = 1'b1; op = OP_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          ok = 1'b1; op = OP_SRA;
        end else begin
          ok = 1'b0;
        end
      end
      OPC_MISC_MEM: begin
        if (f3 == F3_ZERO) begin
          fmt = FMT_I; ok = 1'b1;
          priority if (instr_i == WORD_FENCE_TSO) op = OP_FTSO;
          else if (instr_i == WORD_PAUSE) op = OP_PAUSE;
          else op = OP_FENCE;
        end
      end
      OPC_SYSTEM: begin
        fmt = FMT_I;
        if (instr_i == WORD_ECALL) begin
          ok = 1'b1; op = OP_ECALL;
        end else if (instr_i == WORD_EBREAK) begin
          ok = 1'b1; op = OP_EBREAK;
        end
      end
      OPC_OP_IMM32: begin
        fmt = FMT_I;
        priority if (f3 == F3_ZERO) begin
          ok = 1'b1; op = OP_ADDIW;
        end else if (f3 == F3_SL && f7 == F7_BASE) begin
          ok = 1'b1; op = OP_SLLIW;
        end else if (f3 == F3_SR && f7 == F7_BASE) begin
          ok = 1'b1; op = OP_SRLIW;
        end else if (f3 == F3_SR && f7 == F7_ALT) begin
          ok = 1'b1; op = OP_SRAIW;
        end else begin
          ok = 1'b0;
        end
      end
      OPC_OP32: begin
        fmt = FMT_R;
        priority if (f3 == F3_ZERO && f7 == F7_BASE) begin
          ok = 1'b1; op = OP_ADDW;
        end else if (f3 == F3_ZERO && f7 == F7_ALT) begin
          ok = 1'b1; op = OP_SUBW;
        end else if (f3 == F3_SL && f7 == F7_BASE) begin
          ok = 1'b1; op = OP_SLLW;
        end else if (f3 == F3_SR && f7 == F7_BASE) begin
          ok = 1'b1; op = OP_SRLW;
        end else if (f3 == F3_SR && f7 == F7_ALT) begin
          ok = 1'b1; op = OP_SRAW;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        fmt = FMT_NONE;
      end
    endcase
  end

  // Extract register fields and pack the raw immediate per format
  always_comb begin
    dec_o       = '0;
    dec_o.fmt   = fmt;
    dec_o.op    = ok ? op : '0;
    dec_o.legal = ok;
    unique case (fmt)
      FMT_R: begin
        dec_o.rd  = instr_i[11:7];
        dec_o.rs1 = instr_i[19:15];
        dec_o.rs2 = instr_i[24:20];
      end
      FMT_I: begin
        dec_o.rd  = instr_i[11:7];
        dec_o.rs1 = instr_i[19:15];
        dec_o.imm = {9'b0, instr_i[31:20]};
      end
      FMT_S: begin
        dec_o.rs1 = instr_i[19:15];
        dec_o.rs2 = instr_i[24:20];
        dec_o.imm = {9'b0, instr_i[31:25], instr_i[11:7]};
      end
      FMT_B: begin
        dec_o.rs1 = instr_i[19:15];
        dec_o.rs2 = instr_i[24:20];
        dec_o.imm = {8'b0, instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
      end
      FMT_U: begin
        dec_o.rd  = instr_i[11:7];
        dec_o.imm = {1'b0, instr_i[31:12]};
      end
      FMT_J: begin
        dec_o.rd  = instr_i[11:7];
        dec_o.imm = {instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
      end
      default: begin
        dec_o.rd = '0;
      end
    endcase
  end

endmodule

// File: sv/rv64i_instruction_decoder_top.sv
// Top level of the RV64I instruction decoder: input and result registers.
`timescale 1ns / 1ps
// Usage
//   Input: drive instr_word_i and raise start_i; a transaction is taken at
//   each rising edge with start_i high and busy_o low. busy_o stays low, so
//   a new word may be given in every cycle.
//   Output: done_o is high for exactly one cycle with the decoded format,
//   operation number, legal flag, register indexes and raw immediate.
//   The receiver cannot stall; results must be taken as they appear.
// Pipeline and throughput
//   The accepted word is held in the input register, then decoded into
//   the result register, from which the receiver takes it.
//   One word per cycle sustained; the single decode stage between the two
//   registers sets that figure.
// Reset
//   rst_ni low clears the stage valid flags; no result strobe follows
//   reset until a new transaction is accepted. Payload registers are not
//   cleared.
module rv64i_instruction_decoder_top
  import rvid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] instr_word_i,
  output logic        done_o,
  output logic [2:0]  format_class_o,
  output logic [5:0]  op_id_o,
  output logic        legal_o,
  output logic [4:0]  rd_index_o,
  output logic [4:0]  rs1_index_o,
  output logic [4:0]  rs2_index_o,
  output logic [20:0] immediate_o
);

  logic        accept;
  logic        in_vld_q;
  logic [31:0] instr_q;
  logic        done_q;
  dec_t        dec;
  dec_t        res_q;

  // Never hold off the sender
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Track which stages carry a transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= accept;
      done_q   <= in_vld_q;
    end
  end

  // Capture the instruction word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instr_word_i;
    end
  end

  rvid_decode u_decode (
    .instr_i (instr_q),
    .dec_o   (dec)
  );

  // Hold the decoded result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= dec;
    end
  end

  assign done_o         = done_q;
  assign format_class_o = res_q.fmt;
  assign op_id_o        = res_q.op;
  assign legal_o        = res_q.legal;
  assign rd_index_o     = res_q.rd;
  assign rs1_index_o    = res_q.rs1;
  assign rs2_index_o    = res_q.rs2;
  assign immediate_o    = res_q.imm;

`include "rv64i_instruction_decoder_top_assert.svh"

  `RVID_ASSERT_NEXT(a_accept_to_stage, clk_i, rst_ni, accept, in_vld_q, "accepted word lost")
  `RVID_ASSERT_NEXT(a_stage_to_done, clk_i, rst_ni, in_vld_q, done_o, "result strobe missing")
  `RVID_ASSERT_SAME(a_illegal_op_zero, clk_i, rst_ni, done_o && !legal_o, op_id_o == '0, "illegal op nonzero")
  `RVID_ASSERT_SAME(a_legal_has_fmt, clk_i, rst_ni, done_o && legal_o, format_class_o != FMT_NONE, "legal without format")
  `RVID_ASSERT_SAME(a_none_fields_zero, clk_i, rst_ni, done_o && format_class_o == FMT_NONE, (rd_index_o == '0) && (rs1_index_o == '0) && (rs2_index_o == '0) && (immediate_o == '0), "fields set for unknown opcode")

endmodule
